// ===== hw/rtl/threshold_boundary_search_calibrator_macros.svh =====
// Assertion helpers for the threshold calibrator
`ifndef THRESHOLD_BOUNDARY_SEARCH_CALIBRATOR_MACROS_SVH
`define THRESHOLD_BOUNDARY_SEARCH_CALIBRATOR_MACROS_SVH

// same-cycle implication
`define TBSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tbsc_pkg.sv =====
`default_nettype none

package tbsc_pkg;

    localparam logic [7:0] BATCH_PULSES = 8'd32;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BATCH = 1'b1;

    localparam logic [2:0] CFG_INITIAL_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_MIN_THRESHOLD     = 3'd1;
    localparam logic [2:0] CFG_MAX_THRESHOLD     = 3'd2;
    localparam logic [2:0] CFG_MIN_STEP          = 3'd3;
    localparam logic [2:0] CFG_STEP_FRACTION     = 3'd4;
    localparam logic [2:0] CFG_TARGET_FRACTION   = 3'd5;
    localparam logic [2:0] CFG_ALLOWED_MISREADS  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FAIL,
        ST_DONE
    } status_t;

    typedef enum logic [1:0] {
        FAIL_NONE,
        FAIL_SHAPE,
        FAIL_NO_GOOD
    } fail_t;

    typedef enum logic {
        PHASE_LOWER,
        PHASE_UPPER
    } phase_t;

    typedef struct packed {
        logic [15:0] initial_threshold;
        logic [15:0] min_threshold;
        logic [15:0] max_threshold;
        logic [15:0] min_step;
        logic [7:0]  step_fraction;
        logic [7:0]  target_fraction;
        logic [5:0]  allowed_misreads;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        phase_t      phase;
        logic [15:0] threshold;
        logic [15:0] last_good;
        logic [15:0] lower_found;
        logic [15:0] upper_found;
        fail_t       fail;
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbsc_next.sv =====
`default_nettype none

module tbsc_next
    import tbsc_pkg::*;
(
    input  state_t      state,
    input  cfg_t        cfg,
    input  logic        action,
    input  logic        batch_ok,
    input  logic [5:0]  false_positive_count,
    input  logic [5:0]  false_negative_count,
    output state_t      state_next
);

    logic [15:0]        cur;
    logic [15:0]        remaining;
    logic [23:0]        frac_prod;
    logic [15:0]        frac_step;
    logic [15:0]        step;
    logic [16:0]        down_floor;
    logic [15:0]        down_thr;
    logic [16:0]        up_sum;
    logic [15:0]        up_thr;
    logic [15:0]        fin_upper;
    logic signed [25:0] diff_s;
    logic signed [25:0] tf_s;
    logic signed [25:0] interp_prod;
    logic signed [25:0] interp_total;
    logic [15:0]        interp_thr;
    logic [7:0]         fp_sat;
    logic [7:0]         fn_sat;
    logic               shape_ok;

    assign cur = state.threshold;

    always_comb
    begin
        if (state.phase == PHASE_LOWER)
        begin
            remaining = (cur > cfg.min_threshold) ? (cur - cfg.min_threshold) : 16'd0;
        end
        else
        begin
            remaining = (cfg.max_threshold > cur) ? (cfg.max_threshold - cur) : 16'd0;
        end
    end

    assign frac_prod = {8'd0, remaining} * {16'd0, cfg.step_fraction};
    assign frac_step = frac_prod[23:8];
    assign step      = (frac_step > cfg.min_step) ? frac_step : cfg.min_step;

    assign down_floor = {1'b0, cfg.min_threshold} + {1'b0, step};
    assign down_thr   = ({1'b0, cur} >= down_floor) ? (cur - step) : cfg.min_threshold;

    assign up_sum = {1'b0, cur} + {1'b0, step};
    assign up_thr = (up_sum > {1'b0, cfg.max_threshold}) ? cfg.max_threshold : up_sum[15:0];

    // final value: lower + (upper - lower) * tf / 256, never negative
    assign fin_upper    = batch_ok ? cur : state.last_good;
    assign diff_s       = $signed({10'd0, fin_upper}) - $signed({10'd0, state.lower_found});
    assign tf_s         = $signed({18'd0, cfg.target_fraction});
    assign interp_prod  = diff_s * tf_s;
    assign interp_total = $signed({2'b00, state.lower_found, 8'd0}) + interp_prod;
    assign interp_thr   = interp_total[23:8];

    assign fp_sat   = ({2'b00, false_positive_count} > BATCH_PULSES) ? BATCH_PULSES
                                                                   : {2'b00, false_positive_count};
    assign fn_sat   = ({2'b00, false_negative_count} > BATCH_PULSES) ? BATCH_PULSES
                                                                   : {2'b00, false_negative_count};
    assign shape_ok = (state.phase == PHASE_LOWER) ? (fp_sat > {2'b00, cfg.allowed_misreads})
                                                   : (fn_sat > {2'b00, cfg.allowed_misreads});

    always_comb
    begin
        state_next = state;
        if (action == ACT_START)
        begin
            state_next.status      = ST_RUN;
            state_next.fail        = FAIL_NONE;
            state_next.phase       = PHASE_LOWER;
            state_next.threshold   = cfg.initial_threshold;
            state_next.lower_found = 16'd0;
            state_next.upper_found = 16'd0;
            state_next.last_good   = 16'd0;
        end
        else if (state.status == ST_RUN)
        begin
            if (batch_ok)
            begin
                state_next.last_good = cur;
                if (state.phase == PHASE_LOWER)
                begin
                    if (cur == cfg.min_threshold)
                    begin
                        state_next.lower_found = cur;
                        state_next.last_good   = 16'd0;
                        state_next.threshold   = cfg.initial_threshold;
                        state_next.phase       = PHASE_UPPER;
                    end
                    else
                    begin
                        state_next.threshold = down_thr;
                    end
                end
                else
                begin
                    if (cur == cfg.max_threshold)
                    begin
                        state_next.upper_found = cur;
                        state_next.threshold   = interp_thr;
                        state_next.status      = ST_DONE;
                    end
                    else
                    begin
                        state_next.threshold = up_thr;
                    end
                end
            end
            else if (!shape_ok)
            begin
                state_next.status = ST_FAIL;
                state_next.fail   = FAIL_SHAPE;
            end
            else if (state.last_good == 16'd0)
            begin
                state_next.status = ST_FAIL;
                state_next.fail   = FAIL_NO_GOOD;
            end
            else if (state.phase == PHASE_LOWER)
            begin
                state_next.lower_found = state.last_good;
                state_next.last_good   = 16'd0;
                state_next.threshold   = cfg.initial_threshold;
                state_next.phase       = PHASE_UPPER;
            end
            else
            begin
                state_next.upper_found = state.last_good;
                state_next.threshold   = interp_thr;
                state_next.status      = ST_DONE;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_boundary_search_calibrator.sv =====
// The result word is registered and valid the cycle after its input word is taken.
// Throughput: one word per cycle while out_ready is high; the single result register frees when out_ready is high.
// The whole search update is one pass from the state registers to the result register.
// Reset (rst_n low, async): idle, lower phase, threshold and bounds 0, no failure,
// configuration back to its defaults, no result pending.
`default_nettype none

module threshold_boundary_search_calibrator
    import tbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic        batch_ok,
    input  logic [5:0]  false_positive_count,
    input  logic [5:0]  false_negative_count,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  run_status,
    output logic        search_phase,
    output logic [15:0] sensor_threshold,
    output logic [1:0]  failure_code,
    output logic [15:0] lower_bound,
    output logic [15:0] upper_bound
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_accept;

    assign cfg_ready      = 1'b1;
    assign in_ready       = !out_valid_reg || out_ready;
    assign in_accept      = in_valid && in_ready;
    assign out_valid_next = in_accept || (out_valid_reg && !out_ready);

    tbsc_next u_next (
        .state                (state_reg),
        .cfg                  (cfg_reg),
        .action               (action),
        .batch_ok             (batch_ok),
        .false_positive_count (false_positive_count),
        .false_negative_count (false_negative_count),
        .state_next           (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_threshold <= 16'd2048;
            cfg_reg.min_threshold     <= 16'd0;
            cfg_reg.max_threshold     <= 16'd4095;
            cfg_reg.min_step          <= 16'd1;
            cfg_reg.step_fraction     <= 8'd64;
            cfg_reg.target_fraction   <= 8'd128;
            cfg_reg.allowed_misreads  <= 6'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INITIAL_THRESHOLD: cfg_reg.initial_threshold <= cfg_data;
                CFG_MIN_THRESHOLD:     cfg_reg.min_threshold     <= cfg_data;
                CFG_MAX_THRESHOLD:     cfg_reg.max_threshold     <= cfg_data;
                CFG_MIN_STEP:          cfg_reg.min_step          <= cfg_data;
                CFG_STEP_FRACTION:     cfg_reg.step_fraction     <= cfg_data[7:0];
                CFG_TARGET_FRACTION:   cfg_reg.target_fraction   <= cfg_data[7:0];
                CFG_ALLOWED_MISREADS:  cfg_reg.allowed_misreads  <= cfg_data[5:0];
                default:               ;
            endcase
        end
    end

    // state doubles as the result register: it only moves when the result slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.status      <= ST_IDLE;
            state_reg.phase       <= PHASE_LOWER;
            state_reg.threshold   <= 16'd0;
            state_reg.last_good   <= 16'd0;
            state_reg.lower_found <= 16'd0;
            state_reg.upper_found <= 16'd0;
            state_reg.fail        <= FAIL_NONE;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign run_status       = state_reg.status;
    assign search_phase     = state_reg.phase;
    assign sensor_threshold = state_reg.threshold;
    assign failure_code     = state_reg.fail;
    assign lower_bound      = state_reg.lower_found;
    assign upper_bound      = state_reg.upper_found;

`include "threshold_boundary_search_calibrator_macros.svh"

    `TBSC_ASSERT_NOW(a_fail_matches_status, clk, rst_n, 1'b1, ((state_reg.status == ST_FAIL) == (state_reg.fail != FAIL_NONE)), "failure code disagrees with run status")
    `TBSC_ASSERT_NEXT(a_start_restarts, clk, rst_n, (in_accept && (action == ACT_START)), ((state_reg.status == ST_RUN) && (state_reg.phase == PHASE_LOWER) && (state_reg.lower_found == 16'd0) && (state_reg.upper_found == 16'd0)), "start did not restart the search")
    `TBSC_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !in_accept, ($stable(state_reg.threshold) && $stable(state_reg.status) && $stable(state_reg.last_good)), "search state moved without an input word")
    `TBSC_ASSERT_NEXT(a_result_needs_input, clk, rst_n, (!out_valid_reg && !in_accept), !out_valid_reg, "result word without an input word")

endmodule

`default_nettype wire
